// ===== hw/rtl/rcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfs_pkg
// Shared types, constants and helpers for the RC output failsafe mixer.
// ----------------------------------------------------------------------------
package rcfs_pkg;

	localparam int NUM_OUTPUTS  = 4;
	localparam int NUM_CHANNELS = 16;

	localparam int PULSE_W  = 12;
	localparam int CH_IDX_W = 4;
	localparam int OIDX_W   = 2;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 41;

	localparam logic [PULSE_W-1:0] PULSE_MIN_US = 12'd1000;
	localparam logic [PULSE_W-1:0] PULSE_MAX_US = 12'd2000;
	localparam logic [PULSE_W-1:0] PULSE_MID_US = 12'd1500;

	// rate 0 interval; a nonzero rate gives intervals up to MS_PER_S
	localparam int DEFAULT_INTERVAL_MS = 20;
	localparam int MS_PER_S            = 1000;
	localparam int DIFF_W              = 10;

	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_SERVO  = 2'd1;
	localparam logic [1:0] MODE_SWITCH = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	localparam logic [1:0] FS_HOLD   = 2'd0;
	localparam logic [1:0] FS_STOP   = 2'd1;
	localparam logic [1:0] FS_VALUES = 2'd2;
	localparam logic [1:0] FS_RSVD   = 2'd3;

	localparam logic REQ_STORE  = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FS_SEL = 3'd4;

	typedef struct packed {
		logic               high;
		logic [PULSE_W-1:0] thresh;
		logic [PULSE_W-1:0] failsafe;
		logic               invert;
		logic [RATE_W-1:0]  rate_hz;
		logic [3:0]         src;
		logic [1:0]         mode;
	} setup_t;

	typedef struct packed {
		logic              store;
		logic              latch;
		logic              prep;
		logic              eval;
		logic [OIDX_W-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_upd;
		logic out_free;
	} dp_status_t;

	function automatic logic [1:0] mode_of(input logic [1:0] m);
		return (m == MODE_RSVD) ? MODE_OFF : m;
	endfunction

endpackage

// ===== hw/rtl/rcfs_ifs.sv =====
// ----------------------------------------------------------------------------
// rcfs_ifs
// Request and result stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcfs_req_if import rcfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [CH_IDX_W-1:0] channel_index;
	logic [PULSE_W-1:0]  channel_value;
	logic [TIME_W-1:0]   now_ms;
	logic                link_ok;

	modport source(output valid, req_type, channel_index, channel_value, now_ms, link_ok,
		input ready);
	modport sink(input valid, req_type, channel_index, channel_value, now_ms, link_ok,
		output ready);
endinterface

interface rcfs_res_if import rcfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OIDX_W-1:0]  out_index;
	logic [PULSE_W-1:0] pulse_width;
	logic               switch_level;
	logic               active;
	logic               refreshed;
	logic               last_of_tick;

	modport source(output valid, out_index, pulse_width, switch_level, active, refreshed,
		last_of_tick, input ready);
	modport sink(input valid, out_index, pulse_width, switch_level, active, refreshed,
		last_of_tick, output ready);
endinterface

// ===== hw/rtl/rcfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcfs_ctrl
// Sequencer: accepts items and walks the outputs of an update tick.
// ----------------------------------------------------------------------------
module rcfs_ctrl import rcfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EVAL
	} state_t;

	state_t            state_q;
	logic [OIDX_W-1:0] idx_q;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		cmd.idx   = idx_q;
		cmd.store = accept && !status.req_upd;
		cmd.latch = accept && status.req_upd;
		cmd.prep  = (state_q == ST_PREP);
		cmd.eval  = (state_q == ST_EVAL) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && status.req_upd) begin
						idx_q   <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (status.out_free) begin
						if (idx_q == OIDX_W'(NUM_OUTPUTS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_PREP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rcfs_dp.sv =====
// ----------------------------------------------------------------------------
// rcfs_dp
// Datapath: channel store, setup registers, per-output state, result register.
// ----------------------------------------------------------------------------
module rcfs_dp import rcfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_type,
	input  logic [CH_IDX_W-1:0]   channel_index,
	input  logic [PULSE_W-1:0]    channel_value,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  link_ok,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [OIDX_W-1:0]     res_out_index,
	output logic [PULSE_W-1:0]    res_pulse_width,
	output logic                  res_switch_level,
	output logic                  res_active,
	output logic                  res_refreshed,
	output logic                  res_last_of_tick
);

	logic [PULSE_W-1:0] chan_q [NUM_CHANNELS];
	setup_t             setup_q [NUM_OUTPUTS];
	logic [1:0]         fs_sel_q;
	logic [PULSE_W-1:0] held_pulse_q [NUM_OUTPUTS];
	logic               held_level_q [NUM_OUTPUTS];
	logic               on_q [NUM_OUTPUTS];
	logic [TIME_W-1:0]  lwt_q [NUM_OUTPUTS];
	logic               wo_q [NUM_OUTPUTS];

	logic [TIME_W-1:0]  now_q;
	logic               link_q;
	logic [1:0]         fs_q;

	// prep stage
	logic               lt_def_s1;
	logic               lt_max_s1;
	logic [DIFF_W-1:0]  diffp1_s1;
	logic [PULSE_W-1:0] pulse_s1;
	logic               level_s1;

	logic               out_valid_q;
	logic [OIDX_W-1:0]  out_idx_q;
	logic [PULSE_W-1:0] out_pulse_q;
	logic               out_level_q;
	logic               out_active_q;
	logic               out_refr_q;
	logic               out_last_q;

	setup_t              sp;
	logic [PULSE_W-1:0]  src_val;
	logic signed [13:0]  sv;
	logic [TIME_W-1:0]   diff;

	setup_t              se;
	logic [1:0]          mode_e;
	logic [18:0]         prod;
	logic                too_soon;
	logic                wo_eff;
	logic                on_new;
	logic                wo_new;
	logic                do_write;
	logic [PULSE_W-1:0]  pulse_new;
	logic                level_new;
	setup_t              cfg_s;

	assign status.req_upd  = (req_type == REQ_UPDATE);
	assign status.out_free = !out_valid_q || res_ready;
	assign cfg_s           = setup_t'(cfg_wdata);

	// prep: source value, candidate pulse/level, time difference
	always_comb begin
		sp = setup_q[cmd.idx];
		if (!link_q && fs_q == FS_VALUES) begin
			src_val = sp.failsafe;
		end else if (32'(sp.src) < NUM_CHANNELS) begin
			src_val = chan_q[sp.src];
		end else begin
			src_val = PULSE_MID_US;
		end
		sv = $signed({2'b00, src_val});
		if (sp.invert) begin
			sv = $signed(14'(PULSE_MIN_US) + 14'(PULSE_MAX_US)) - sv;
		end
		if (sv < $signed({2'b00, PULSE_MIN_US})) begin
			sv = $signed({2'b00, PULSE_MIN_US});
		end
		if (sv > $signed({2'b00, PULSE_MAX_US})) begin
			sv = $signed({2'b00, PULSE_MAX_US});
		end
		diff = now_q - lwt_q[cmd.idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			pulse_s1  <= sv[PULSE_W-1:0];
			level_s1  <= sp.high ? (src_val >= sp.thresh) : (src_val < sp.thresh);
			lt_def_s1 <= diff < TIME_W'(DEFAULT_INTERVAL_MS);
			lt_max_s1 <= diff < TIME_W'(MS_PER_S);
			diffp1_s1 <= diff[DIFF_W-1:0] + 1'b1;
		end
	end

	// eval: too soon if (diff + 1) * rate <= 1000 for a nonzero rate, else if diff < 20
	always_comb begin
		se       = setup_q[cmd.idx];
		mode_e   = mode_of(se.mode);
		prod     = 19'(diffp1_s1) * 19'(se.rate_hz);
		wo_eff   = on_q[cmd.idx] && wo_q[cmd.idx];
		if (se.rate_hz == '0) begin
			too_soon = wo_eff && lt_def_s1;
		end else begin
			too_soon = wo_eff && lt_max_s1 && (prod <= 19'(MS_PER_S));
		end
		on_new    = on_q[cmd.idx];
		wo_new    = wo_q[cmd.idx];
		do_write  = 1'b0;
		pulse_new = held_pulse_q[cmd.idx];
		level_new = held_level_q[cmd.idx];
		if (mode_e != MODE_OFF) begin
			if (!link_q && fs_q == FS_STOP) begin
				on_new = 1'b0;
			end else begin
				on_new = 1'b1;
				wo_new = wo_eff;
				if (!(!link_q && fs_q == FS_HOLD) && !too_soon) begin
					do_write = 1'b1;
					wo_new   = 1'b1;
					if (mode_e == MODE_SERVO) begin
						pulse_new = pulse_s1;
					end else begin
						level_new = level_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				chan_q[c] <= PULSE_MID_US;
			end
			for (int o = 0; o < NUM_OUTPUTS; o++) begin
				setup_q[o]      <= '0;
				held_pulse_q[o] <= PULSE_MID_US;
				held_level_q[o] <= 1'b0;
				on_q[o]         <= 1'b0;
				lwt_q[o]        <= '0;
				wo_q[o]         <= 1'b0;
			end
			fs_sel_q    <= FS_HOLD;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (32'(cfg_idx) < NUM_OUTPUTS) begin
					setup_q[cfg_idx[OIDX_W-1:0]] <= cfg_s;
					if (mode_of(setup_q[cfg_idx[OIDX_W-1:0]].mode) != mode_of(cfg_s.mode)) begin
						wo_q[cfg_idx[OIDX_W-1:0]] <= 1'b0;
						on_q[cfg_idx[OIDX_W-1:0]] <= (mode_of(cfg_s.mode) != MODE_OFF);
					end
				end else if (cfg_idx == CFG_FS_SEL) begin
					fs_sel_q <= cfg_wdata[1:0];
				end
			end
			if (cmd.store && 32'(channel_index) < NUM_CHANNELS) begin
				chan_q[channel_index] <= channel_value;
			end
			if (cmd.eval) begin
				on_q[cmd.idx]         <= on_new;
				wo_q[cmd.idx]         <= wo_new;
				held_pulse_q[cmd.idx] <= pulse_new;
				held_level_q[cmd.idx] <= level_new;
				if (do_write) begin
					lwt_q[cmd.idx] <= now_q;
				end
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			now_q  <= now_ms;
			link_q <= link_ok;
			fs_q   <= (fs_sel_q == FS_RSVD) ? FS_HOLD : fs_sel_q;
		end
		if (cmd.eval) begin
			out_idx_q    <= cmd.idx;
			out_pulse_q  <= pulse_new;
			out_level_q  <= (mode_e == MODE_SWITCH) && on_new && level_new;
			out_active_q <= on_new;
			out_refr_q   <= do_write;
			out_last_q   <= (cmd.idx == OIDX_W'(NUM_OUTPUTS - 1));
		end
	end

	assign res_valid        = out_valid_q;
	assign res_out_index    = out_idx_q;
	assign res_pulse_width  = out_pulse_q;
	assign res_switch_level = out_level_q;
	assign res_active       = out_active_q;
	assign res_refreshed    = out_refr_q;
	assign res_last_of_tick = out_last_q;

endmodule

// ===== hw/rtl/rc_output_failsafe_mixer.sv =====
// ----------------------------------------------------------------------------
// rc_output_failsafe_mixer
// Store item: taken when idle, no result. Update item: a prepare and an
// evaluate step per output after the accept, one result each; no new item
// is taken until the walk of all outputs is done, and a waiting result
// stalls the walk. The next item is taken while the last result waits.
// Reset: all outputs disabled, hold-last, channels and pulses at mid value.
// ----------------------------------------------------------------------------
module rc_output_failsafe_mixer import rcfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rcfs_req_if.sink              req,
	rcfs_res_if.source            res
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	rcfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rcfs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.req_type         (req.req_type),
		.channel_index    (req.channel_index),
		.channel_value    (req.channel_value),
		.now_ms           (req.now_ms),
		.link_ok          (req.link_ok),
		.cmd              (cmd),
		.status           (status),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_out_index    (res.out_index),
		.res_pulse_width  (res.pulse_width),
		.res_switch_level (res.switch_level),
		.res_active       (res.active),
		.res_refreshed    (res.refreshed),
		.res_last_of_tick (res.last_of_tick)
	);

endmodule

// ===== hw/rtl/rcfs_chk.sv =====
// ----------------------------------------------------------------------------
// rcfs_chk
// Port-level checks for the RC output failsafe mixer.
// ----------------------------------------------------------------------------
module rcfs_chk import rcfs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [OIDX_W-1:0] res_out_index,
	input logic              res_switch_level,
	input logic              res_active,
	input logic              res_refreshed,
	input logic              res_last_of_tick
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last_of_tick == (res_out_index == OIDX_W'(NUM_OUTPUTS - 1))))
		else $error("last_of_tick does not match final output");

	a_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_active |-> !res_switch_level && !res_refreshed)
		else $error("inactive output drives or refreshes");

	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last_of_tick |-> !req_ready)
		else $error("new item taken during a tick");

endmodule

bind rc_output_failsafe_mixer rcfs_chk u_rcfs_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_out_index    (res.out_index),
	.res_switch_level (res.switch_level),
	.res_active       (res.active),
	.res_refreshed    (res.refreshed),
	.res_last_of_tick (res.last_of_tick)
);
